[rtl/core/fraction_add_reduce_macros.svh]
// ----------------------------------------------------------------------------
// fraction_add_reduce_macros
// Assertion macros shared by the fraction adder checks.
// ----------------------------------------------------------------------------
`ifndef FRACTION_ADD_REDUCE_MACROS_SVH
`define FRACTION_ADD_REDUCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAR_AST_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("far check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define FAR_AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("far check failed: next-cycle rule");

// Next-cycle implication that stays live through reset.
`define FAR_AST_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("far check failed: reset rule");

`endif

[rtl/core/far_pkg.sv]
// ----------------------------------------------------------------------------
// far_pkg
// Widths, types and output limits of the fraction adder.
// ----------------------------------------------------------------------------
package far_pkg;

    // Input numerator width; denominators are one bit narrower
    localparam int IN_WIDTH  = 16;
    localparam int DEN_W     = IN_WIDTH - 1;
    localparam int PROD_W    = 2 * IN_WIDTH - 1;
    localparam int SUM_W     = 2 * IN_WIDTH;
    localparam int OUT_NUM_W = 32;
    localparam int OUT_DEN_W = 30;
    localparam int CMP_W     = (SUM_W > OUT_NUM_W + 1) ? SUM_W : OUT_NUM_W + 1;
    localparam int CNT_W     = $clog2(SUM_W + 1);

    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [CMP_W-1:0]  t_cmp;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Saturation limits of the reduced result
    localparam t_cmp NUM_POS_MAX = t_cmp'((65'd1 << (OUT_NUM_W - 1)) - 65'd1);
    localparam t_cmp NUM_NEG_MAX = t_cmp'(65'd1 << (OUT_NUM_W - 1));
    localparam t_cmp DEN_MAX     = t_cmp'((65'd1 << OUT_DEN_W) - 65'd1);

endpackage

[rtl/core/far_in_if.sv]
// ----------------------------------------------------------------------------
// far_in_if
// Input channel of the fraction adder: two fractions per item.
// ----------------------------------------------------------------------------
interface far_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [far_pkg::IN_WIDTH-1:0] a_num;
    logic        [far_pkg::DEN_W-1:0]    a_den;
    logic signed [far_pkg::IN_WIDTH-1:0] b_num;
    logic        [far_pkg::DEN_W-1:0]    b_den;

    modport source (output valid, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, a_num, a_den, b_num, b_den, output ready);
endinterface

[rtl/core/far_out_if.sv]
// ----------------------------------------------------------------------------
// far_out_if
// Output channel of the fraction adder: one reduced sum per item.
// ----------------------------------------------------------------------------
interface far_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [far_pkg::OUT_NUM_W-1:0] sum_num;
    logic        [far_pkg::OUT_DEN_W-1:0] sum_den;

    modport source (output valid, sum_num, sum_den, input ready);
    modport sink   (input valid, sum_num, sum_den, output ready);
endinterface

[rtl/core/fraction_add_reduce.sv]
// ----------------------------------------------------------------------------
// fraction_add_reduce
// Adds two fractions and reduces the sum to lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries a_num/a_den and b_num/b_den; an item is taken when valid and
//   ready are both high. o_out carries sum_num/sum_den with the sign on the
//   numerator and a denominator of at least 1; a zero sum gives 0/1.
//   A zero input denominator counts as 1.
// Timing:
//   One item at a time: shift-add multiply (one multiplier bit per cycle),
//   sign merge, binary gcd (a shift or subtract per cycle, then an exit
//   check), restoring division (a quotient bit per cycle) and a load of
//   the output register; a zero sum skips gcd and division. The next
//   item can be taken in the cycle after the load.
// Reset:
//   i_rst_n is synchronous, active low; it empties the output register and
//   returns the sequencer to idle, ready for an item.
// Stall:
//   The result sits in the output register until taken; a new item is
//   accepted meanwhile, and its result waits in the last step if the
//   register is still full.
// ----------------------------------------------------------------------------
module fraction_add_reduce (
    input  logic      i_clk,
    input  logic      i_rst_n,
    far_in_if.sink    i_in,
    far_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SIGN,
        S_GCD,
        S_DIV,
        S_FIN
    } t_state;

    t_state              r_state;
    far_pkg::t_cnt       r_cnt;
    logic                r_a_neg;
    logic                r_b_neg;
    logic                r_neg;
    far_pkg::t_prod      r_ma;
    far_pkg::t_prod      r_mb;
    far_pkg::t_prod      r_mbd;
    logic [far_pkg::DEN_W-1:0] r_qa;
    logic [far_pkg::DEN_W-1:0] r_qb;
    far_pkg::t_prod      r_t1;
    far_pkg::t_prod      r_t2;
    far_pkg::t_prod      r_den;
    far_pkg::t_sum       r_x;
    far_pkg::t_sum       r_y;
    far_pkg::t_sum       r_nm;
    far_pkg::t_sum       r_nd;
    far_pkg::t_sum       r_rm;
    far_pkg::t_sum       r_rd;
    logic                r_o_valid;
    logic [far_pkg::OUT_NUM_W-1:0] r_o_num;
    logic [far_pkg::OUT_DEN_W-1:0] r_o_den;

    // Input split: magnitudes and denominators with zero read as one
    logic [far_pkg::IN_WIDTH-1:0] a_raw;
    logic [far_pkg::IN_WIDTH-1:0] b_raw;
    logic [far_pkg::IN_WIDTH-1:0] a_mag;
    logic [far_pkg::IN_WIDTH-1:0] b_mag;
    logic [far_pkg::DEN_W-1:0]    a_d;
    logic [far_pkg::DEN_W-1:0]    b_d;

    assign a_raw = i_in.a_num;
    assign b_raw = i_in.b_num;
    assign a_mag = a_raw[far_pkg::IN_WIDTH-1] ? (~a_raw + 1'b1) : a_raw;
    assign b_mag = b_raw[far_pkg::IN_WIDTH-1] ? (~b_raw + 1'b1) : b_raw;
    assign a_d   = (i_in.a_den == '0) ? far_pkg::DEN_W'(1) : i_in.a_den;
    assign b_d   = (i_in.b_den == '0) ? far_pkg::DEN_W'(1) : i_in.b_den;

    // Shift-add multiply step: one multiplier bit per cycle
    far_pkg::t_prod n_t1;
    far_pkg::t_prod n_t2;
    far_pkg::t_prod n_den;

    assign n_t1  = r_t1  + (r_qb[0] ? r_ma  : '0);
    assign n_t2  = r_t2  + (r_qa[0] ? r_mb  : '0);
    assign n_den = r_den + (r_qa[0] ? r_mbd : '0);

    // Sign merge of the two cross products
    far_pkg::t_sum t1e;
    far_pkg::t_sum t2e;
    far_pkg::t_sum s_add;
    far_pkg::t_sum s_diff;
    far_pkg::t_sum s_mag;
    logic          s_ge;
    logic          s_neg;

    assign t1e    = far_pkg::t_sum'(r_t1);
    assign t2e    = far_pkg::t_sum'(r_t2);
    assign s_add  = t1e + t2e;
    assign s_ge   = (t1e >= t2e);
    assign s_diff = s_ge ? (t1e - t2e) : (t2e - t1e);
    assign s_mag  = (r_a_neg == r_b_neg) ? s_add : s_diff;
    assign s_neg  = (r_a_neg == r_b_neg) ? r_a_neg : (s_ge ? r_a_neg : r_b_neg);

    // Binary gcd step
    far_pkg::t_sum g_xy;
    far_pkg::t_sum g_yx;
    logic          g_ge;

    assign g_ge = (r_x >= r_y);
    assign g_xy = r_x - r_y;
    assign g_yx = r_y - r_x;

    // Restoring division step, numerator and denominator side by side
    logic [far_pkg::SUM_W:0] d_trm;
    logic [far_pkg::SUM_W:0] d_trd;
    logic [far_pkg::SUM_W:0] d_div;
    logic [far_pkg::SUM_W:0] d_subm;
    logic [far_pkg::SUM_W:0] d_subd;
    logic                    d_fm;
    logic                    d_fd;

    assign d_trm  = {r_rm, r_nm[far_pkg::SUM_W-1]};
    assign d_trd  = {r_rd, r_nd[far_pkg::SUM_W-1]};
    assign d_div  = {1'b0, r_y};
    assign d_fm   = (d_trm >= d_div);
    assign d_fd   = (d_trd >= d_div);
    assign d_subm = d_trm - d_div;
    assign d_subd = d_trd - d_div;

    // Output saturation and sign
    far_pkg::t_cmp o_mag;
    far_pkg::t_cmp o_lim;
    far_pkg::t_cmp o_sat;
    far_pkg::t_cmp o_dext;
    far_pkg::t_cmp o_dsat;
    logic [far_pkg::OUT_NUM_W-1:0] o_num;
    logic                          o_load;

    assign o_mag  = far_pkg::t_cmp'(r_nm);
    assign o_lim  = r_neg ? far_pkg::NUM_NEG_MAX : far_pkg::NUM_POS_MAX;
    assign o_sat  = (o_mag > o_lim) ? o_lim : o_mag;
    assign o_num  = r_neg ? (~o_sat[far_pkg::OUT_NUM_W-1:0] + 1'b1)
                          : o_sat[far_pkg::OUT_NUM_W-1:0];
    assign o_dext = far_pkg::t_cmp'(r_nd);
    assign o_dsat = (o_dext > far_pkg::DEN_MAX) ? far_pkg::DEN_MAX : o_dext;
    assign o_load = (r_state == S_FIN) && (!r_o_valid || o_out.ready);

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_load) begin
                r_o_valid <= 1'b1;
                r_o_num   <= o_num;
                r_o_den   <= o_dsat[far_pkg::OUT_DEN_W-1:0];
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_a_neg <= a_raw[far_pkg::IN_WIDTH-1];
                        r_b_neg <= b_raw[far_pkg::IN_WIDTH-1];
                        r_ma    <= far_pkg::t_prod'(a_mag);
                        r_mb    <= far_pkg::t_prod'(b_mag);
                        r_mbd   <= far_pkg::t_prod'(b_d);
                        r_qa    <= a_d;
                        r_qb    <= b_d;
                        r_t1    <= '0;
                        r_t2    <= '0;
                        r_den   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_t1  <= n_t1;
                    r_t2  <= n_t2;
                    r_den <= n_den;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb << 1;
                    r_mbd <= r_mbd << 1;
                    r_qa  <= r_qa >> 1;
                    r_qb  <= r_qb >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == far_pkg::CNT_W'(far_pkg::DEN_W - 1)) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    if (s_mag == '0) begin
                        // zero sum reads as 0/1
                        r_nm    <= '0;
                        r_nd    <= far_pkg::SUM_W'(1);
                        r_neg   <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_x     <= s_mag;
                        r_y     <= far_pkg::t_sum'(r_den);
                        r_nm    <= s_mag;
                        r_nd    <= far_pkg::t_sum'(r_den);
                        r_neg   <= s_neg;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_x == '0) begin
                        // odd gcd part left in r_y; common twos already shifted out
                        r_rm    <= '0;
                        r_rd    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x  <= r_x >> 1;
                        r_y  <= r_y >> 1;
                        r_nm <= r_nm >> 1;
                        r_nd <= r_nd >> 1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (g_ge) begin
                        r_x <= g_xy >> 1;
                    end else begin
                        r_y <= g_yx >> 1;
                    end
                end
                S_DIV: begin
                    r_rm  <= d_fm ? d_subm[far_pkg::SUM_W-1:0] : d_trm[far_pkg::SUM_W-1:0];
                    r_rd  <= d_fd ? d_subd[far_pkg::SUM_W-1:0] : d_trd[far_pkg::SUM_W-1:0];
                    r_nm  <= {r_nm[far_pkg::SUM_W-2:0], d_fm};
                    r_nd  <= {r_nd[far_pkg::SUM_W-2:0], d_fd};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == far_pkg::CNT_W'(far_pkg::SUM_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (o_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs
    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_o_valid;
    assign o_out.sum_num = r_o_num;
    assign o_out.sum_den = r_o_den;

endmodule

[rtl/core/far_checker.sv]
// ----------------------------------------------------------------------------
// far_checker
// Port-level checks of the fraction adder, bound to the top level.
// ----------------------------------------------------------------------------
`include "fraction_add_reduce_macros.svh"

module far_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [far_pkg::OUT_NUM_W-1:0] i_sum_num,
    input logic        [far_pkg::OUT_DEN_W-1:0] i_sum_den
);

    // a stalled result stays offered
    `FAR_AST_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // one item at a time: busy right after an accept
    `FAR_AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // denominator is never zero
    `FAR_AST_NOW(a_den_nonzero, i_clk, i_rst_n, i_out_valid, i_sum_den != '0)
    // zero sum comes out as 0/1
    `FAR_AST_NOW(a_zero_sum, i_clk, i_rst_n, i_out_valid && (i_sum_num == '0), i_sum_den == far_pkg::OUT_DEN_W'(1))
    // reset empties the output register
    `FAR_AST_RST(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind fraction_add_reduce far_checker u_far_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sum_num   (o_out.sum_num),
    .i_sum_den   (o_out.sum_den)
);
